>>> hdl/lmpe_pkg.sv
// Shared types and constants for the LED mode PWM effects unit.
// No dependencies; imported by every module of the block.
package lmpe_pkg;

    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IX_W = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;

    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_ON       = 3'd1,
        MODE_BLINK    = 3'd2,
        MODE_GLOW     = 3'd3,
        MODE_FADE_ON  = 3'd4,
        MODE_FADE_OFF = 3'd5
    } mode_t;

    typedef enum logic [CFG_IX_W-1:0] {
        REG_BLINK_PERIOD_MS = 3'd0,
        REG_GLOW_STEP_MS    = 3'd1,
        REG_GLOW_STEP_SIZE  = 3'd2,
        REG_FADE_STEP_MS    = 3'd3,
        REG_FADE_STEP_SIZE  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0]        blink_period_ms;
        logic [15:0]        glow_step_ms;
        logic [LEVEL_W-1:0] glow_step_size;
        logic [15:0]        fade_step_ms;
        logic [LEVEL_W-1:0] fade_step_size;
    } cfg_regs_t;

    localparam logic [15:0]        RST_BLINK_PERIOD_MS = 16'd750;
    localparam logic [15:0]        RST_GLOW_STEP_MS    = 16'd75;
    localparam logic [LEVEL_W-1:0] RST_GLOW_STEP_SIZE  = 8'd25;
    localparam logic [15:0]        RST_FADE_STEP_MS    = 16'd75;
    localparam logic [LEVEL_W-1:0] RST_FADE_STEP_SIZE  = 8'd25;

endpackage

>>> hdl/lmpe_cfg_regs.sv
// Configuration register file for the LED mode PWM effects unit.
// Depends on lmpe_pkg; writes out of range are dropped.
module lmpe_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lmpe_pkg::CFG_IX_W-1:0] cfg_index,
    input  logic [lmpe_pkg::CFG_W-1:0]    cfg_data,
    output lmpe_pkg::cfg_regs_t           cfg
);
    import lmpe_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_BLINK_PERIOD_MS: cfg_next.blink_period_ms = cfg_data;
                REG_GLOW_STEP_MS:    cfg_next.glow_step_ms    = cfg_data;
                REG_GLOW_STEP_SIZE:  cfg_next.glow_step_size  = cfg_data[LEVEL_W-1:0];
                REG_FADE_STEP_MS:    cfg_next.fade_step_ms    = cfg_data;
                REG_FADE_STEP_SIZE:  cfg_next.fade_step_size  = cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_period_ms <= RST_BLINK_PERIOD_MS;
            cfg_reg.glow_step_ms    <= RST_GLOW_STEP_MS;
            cfg_reg.glow_step_size  <= RST_GLOW_STEP_SIZE;
            cfg_reg.fade_step_ms    <= RST_FADE_STEP_MS;
            cfg_reg.fade_step_size  <= RST_FADE_STEP_SIZE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/lmpe_effect_core.sv
// Effect state and level computation for the LED mode PWM effects unit.
// Depends on lmpe_pkg; state advances only on step.
module lmpe_effect_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [2:0]                   mode,
    input  logic [lmpe_pkg::TIME_W-1:0]  now_ms,
    input  lmpe_pkg::cfg_regs_t          cfg,
    output logic [lmpe_pkg::LEVEL_W-1:0] level
);
    import lmpe_pkg::*;

    logic [TIME_W-1:0]  blink_last_reg, blink_last_next;
    logic [LEVEL_W-1:0] blink_level_reg, blink_level_next;
    logic [TIME_W-1:0]  glow_last_reg, glow_last_next;
    logic [LEVEL_W-1:0] glow_level_reg, glow_level_next;
    logic               glow_rising_reg, glow_rising_next;
    logic [TIME_W-1:0]  rise_last_reg, rise_last_next;
    logic [LEVEL_W-1:0] rise_level_reg, rise_level_next;
    logic [TIME_W-1:0]  fall_last_reg, fall_last_next;
    logic [LEVEL_W-1:0] fall_level_reg, fall_level_next;

    logic               blink_due, glow_due, rise_due, fall_due;
    logic [LEVEL_W:0]   glow_sum, rise_sum;
    logic [LEVEL_W-1:0] glow_up, glow_down, rise_up, fall_down;

    // wrapping elapsed time against each interval
    assign blink_due = (now_ms - blink_last_reg) >= {16'd0, cfg.blink_period_ms};
    assign glow_due  = (now_ms - glow_last_reg)  >= {16'd0, cfg.glow_step_ms};
    assign rise_due  = (now_ms - rise_last_reg)  >= {16'd0, cfg.fade_step_ms};
    assign fall_due  = (now_ms - fall_last_reg)  >= {16'd0, cfg.fade_step_ms};

    assign glow_sum  = {1'b0, glow_level_reg} + {1'b0, cfg.glow_step_size};
    assign glow_up   = (glow_sum >= {1'b0, LEVEL_MAX}) ? LEVEL_MAX : glow_sum[LEVEL_W-1:0];
    assign glow_down = (cfg.glow_step_size >= glow_level_reg) ? LEVEL_MIN
                     : glow_level_reg - cfg.glow_step_size;
    assign rise_sum  = {1'b0, rise_level_reg} + {1'b0, cfg.fade_step_size};
    assign rise_up   = (rise_sum >= {1'b0, LEVEL_MAX}) ? LEVEL_MAX : rise_sum[LEVEL_W-1:0];
    assign fall_down = (cfg.fade_step_size >= fall_level_reg) ? LEVEL_MIN
                     : fall_level_reg - cfg.fade_step_size;

    always_comb begin
        blink_last_next  = blink_last_reg;
        blink_level_next = blink_level_reg;
        glow_last_next   = glow_last_reg;
        glow_level_next  = glow_level_reg;
        glow_rising_next = glow_rising_reg;
        rise_last_next   = rise_last_reg;
        rise_level_next  = rise_level_reg;
        fall_last_next   = fall_last_reg;
        fall_level_next  = fall_level_reg;
        level            = LEVEL_MIN;
        unique case (mode_t'(mode))
            MODE_OFF: level = LEVEL_MIN;
            MODE_ON:  level = LEVEL_MAX;
            MODE_BLINK: begin
                if (blink_due) begin
                    blink_last_next  = now_ms;
                    blink_level_next = (blink_level_reg == LEVEL_MIN) ? LEVEL_MAX : LEVEL_MIN;
                end
                level = blink_level_next;
            end
            MODE_GLOW: begin
                if (glow_due) begin
                    glow_last_next = now_ms;
                    if (glow_rising_reg) begin
                        glow_level_next = glow_up;
                        if (glow_up == LEVEL_MAX) begin
                            glow_rising_next = 1'b0;
                        end
                    end else begin
                        glow_level_next = glow_down;
                        if (glow_down == LEVEL_MIN) begin
                            glow_rising_next = 1'b1;
                        end
                    end
                end
                level = glow_level_next;
            end
            MODE_FADE_ON: begin
                if (rise_due) begin
                    rise_last_next  = now_ms;
                    rise_level_next = rise_up;
                end
                level = rise_level_next;
            end
            MODE_FADE_OFF: begin
                if (fall_due) begin
                    fall_last_next  = now_ms;
                    fall_level_next = fall_down;
                end
                level = fall_level_next;
            end
            default: level = LEVEL_MIN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_last_reg  <= '0;
            blink_level_reg <= LEVEL_MIN;
            glow_last_reg   <= '0;
            glow_level_reg  <= LEVEL_MIN;
            glow_rising_reg <= 1'b1;
            rise_last_reg   <= '0;
            rise_level_reg  <= LEVEL_MIN;
            fall_last_reg   <= '0;
            fall_level_reg  <= LEVEL_MIN;
        end else if (step) begin
            blink_last_reg  <= blink_last_next;
            blink_level_reg <= blink_level_next;
            glow_last_reg   <= glow_last_next;
            glow_level_reg  <= glow_level_next;
            glow_rising_reg <= glow_rising_next;
            rise_last_reg   <= rise_last_next;
            rise_level_reg  <= rise_level_next;
            fall_last_reg   <= fall_last_next;
            fall_level_reg  <= fall_level_next;
        end
    end

endmodule

>>> hdl/led_mode_pwm_effects_unit.sv
// LED mode PWM effects unit: one PWM level word per mode/timestamp word.
// The block takes one input word every cycle while the result side is not stalled, and
// returns its level through the input register, then the result register; the effect state
// updates in the cycle that moves a word from the input register to the result register, so
// back-to-back words see the state left by their predecessor. Configuration writes are
// accepted every cycle and must be issued only while the block holds no word.
// Depends on lmpe_pkg, lmpe_cfg_regs and lmpe_effect_core.
module led_mode_pwm_effects_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_mode,
    input  logic [lmpe_pkg::TIME_W-1:0]   s_now_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lmpe_pkg::LEVEL_W-1:0]  m_pwm_level,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lmpe_pkg::CFG_IX_W-1:0] cfg_index,
    input  logic [lmpe_pkg::CFG_W-1:0]    cfg_data
);
    import lmpe_pkg::*;

    cfg_regs_t          cfg;
    logic               in_valid_reg;
    logic [2:0]         in_mode_reg;
    logic [TIME_W-1:0]  in_now_reg;
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [LEVEL_W-1:0] level;
    logic               advance;

    // move a word to the result register when it is empty or being drained
    assign advance     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready     = !in_valid_reg || advance;
    assign m_valid     = out_valid_reg;
    assign m_pwm_level = out_level_reg;

    lmpe_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lmpe_effect_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .mode    (in_mode_reg),
        .now_ms  (in_now_reg),
        .cfg     (cfg),
        .level   (level)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_now_reg  <= s_now_ms;
        end
        if (advance) begin
            out_level_reg <= level;
        end
    end

endmodule

>>> hdl/lmpe_checker.sv
// Port-level checker for led_mode_pwm_effects_unit, bound to the top level.
// Depends on lmpe_pkg for field widths.
module lmpe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [lmpe_pkg::LEVEL_W-1:0]  m_pwm_level,
    input logic                          cfg_ready
);
    import lmpe_pkg::*;

    // reset empties the result side
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pwm_level))
        else $error("stalled result word changed");

    // a word taken while the result is stalled fills the only free slot
    a_fill_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && m_valid && !m_ready |=> m_ready || !s_ready)
        else $error("input accepted with both stages full");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && !s_ready |=> m_ready || !s_ready)
        else $error("input reopened while result still stalled");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind led_mode_pwm_effects_unit lmpe_checker u_lmpe_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_pwm_level (m_pwm_level),
    .cfg_ready   (cfg_ready)
);

>>> test/tb_top.sv
// Self-checking bench for led_mode_pwm_effects_unit: directed words, then randomized
// setting phases, each checked against an in-bench model of the effect state.
// Depends on lmpe_pkg and the unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lmpe_pkg::*;

    localparam int WATCHDOG_LIMIT = 1500;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 62;

    localparam logic [2:0] MODE_SPARE_LO   = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI   = 3'd7;
    localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;
    localparam logic       ROW_WORD        = 1'b0;
    localparam logic       ROW_REG         = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  code;       // mode for a word, register index for a write
        logic [31:0] val;        // timestamp for a word, data for a write
        logic        typed;
        logic [7:0]  want_level;
    } row_t;

    localparam int NROWS = 32;
    localparam row_t SCRIPT [NROWS] = '{
        '{ROW_WORD, MODE_OFF,       32'd0,          1'b1, 8'd0},
        '{ROW_WORD, MODE_ON,        32'hFFFF_FFFF,  1'b1, 8'd255},
        '{ROW_WORD, MODE_SPARE_LO,  32'd123,        1'b1, 8'd0},
        '{ROW_WORD, MODE_SPARE_HI,  32'hFFFF_FFFF,  1'b1, 8'd0},
        '{ROW_WORD, MODE_BLINK,     32'd0,          1'b1, 8'd0},
        '{ROW_WORD, MODE_BLINK,     32'd749,        1'b1, 8'd0},
        '{ROW_WORD, MODE_BLINK,     32'd750,        1'b1, 8'd255},
        '{ROW_WORD, MODE_BLINK,     32'd1499,       1'b1, 8'd255},
        '{ROW_WORD, MODE_BLINK,     32'd1500,       1'b1, 8'd0},
        '{ROW_WORD, MODE_GLOW,      32'd75,         1'b1, 8'd25},
        '{ROW_WORD, MODE_GLOW,      32'd149,        1'b1, 8'd25},
        '{ROW_WORD, MODE_GLOW,      32'd150,        1'b1, 8'd50},
        '{ROW_WORD, MODE_FADE_ON,   32'd74,         1'b1, 8'd0},
        '{ROW_WORD, MODE_FADE_ON,   32'hFFFF_FFFF,  1'b1, 8'd25},
        // elapsed time wraps through zero here
        '{ROW_WORD, MODE_FADE_ON,   32'd74,         1'b1, 8'd50},
        '{ROW_WORD, MODE_FADE_OFF,  32'd1000,       1'b1, 8'd0},
        '{ROW_WORD, MODE_OFF,       32'd0,          1'b1, 8'd0},
        '{ROW_WORD, MODE_GLOW,      32'd150,        1'b1, 8'd50},
        '{ROW_REG,  REG_GLOW_STEP_MS,   32'd0,      1'b0, 8'd0},
        '{ROW_REG,  REG_GLOW_STEP_SIZE, 32'h01FF,   1'b0, 8'd0},
        '{ROW_REG,  REG_UNMAPPED_LO,    32'hFFFF,   1'b0, 8'd0},
        // zero interval: every glow word steps, full size hits both ends
        '{ROW_WORD, MODE_GLOW,      32'd150,        1'b1, 8'd255},
        '{ROW_WORD, MODE_GLOW,      32'd150,        1'b1, 8'd0},
        '{ROW_REG,  REG_FADE_STEP_SIZE, 32'd0,      1'b0, 8'd0},
        '{ROW_REG,  REG_FADE_STEP_MS,   32'd0,      1'b0, 8'd0},
        '{ROW_WORD, MODE_FADE_ON,   32'h8000_0000,  1'b1, 8'd50},
        '{ROW_REG,  REG_GLOW_STEP_SIZE, 32'd0,      1'b0, 8'd0},
        '{ROW_WORD, MODE_GLOW,      32'd5,          1'b1, 8'd0},
        '{ROW_WORD, MODE_GLOW,      32'd6,          1'b0, 8'd0},
        '{ROW_REG,  REG_BLINK_PERIOD_MS, 32'hFFFF,  1'b0, 8'd0},
        '{ROW_WORD, MODE_BLINK,     32'd67034,      1'b1, 8'd0},
        '{ROW_WORD, MODE_BLINK,     32'd67035,      1'b1, 8'd255}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [2:0]            s_mode;
    logic [TIME_W-1:0]     s_now_ms;
    logic                  m_valid;
    logic                  m_ready;
    logic [LEVEL_W-1:0]    m_pwm_level;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    led_mode_pwm_effects_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pwm_level (m_pwm_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // effect state and settings as the unit should hold them
    logic [15:0]        blink_ms, glow_ms, fade_ms;
    logic [7:0]         glow_sz, fade_sz;
    logic [31:0]        blink_t, glow_t, up_t, down_t;
    logic [7:0]         blink_lvl, glow_lvl, up_lvl, down_lvl;
    logic               glow_up;

    logic [7:0]         level_q [$];
    int                 err_count;
    int                 words_sent;
    int                 regs_written;
    int                 levels_seen;
    int                 idle_cycles;
    bit                 no_idle;
    bit                 hold_pending;

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        err_count++;
    endtask

    function automatic logic [7:0] add_sat(input logic [7:0] lvl, input logic [7:0] sz);
        logic [8:0] sum;
        sum = {1'b0, lvl} + {1'b0, sz};
        return (sum >= 9'd255) ? LEVEL_MAX : sum[7:0];
    endfunction

    function automatic logic [7:0] sub_sat(input logic [7:0] lvl, input logic [7:0] sz);
        return (sz >= lvl) ? LEVEL_MIN : lvl - sz;
    endfunction

    // true when the interval has run out; reload the timestamp then
    function automatic bit step_due(inout logic [31:0] last, input logic [31:0] now,
                                    input logic [15:0] ivl);
        logic [31:0] elapsed;
        elapsed = now - last;
        if (elapsed >= 32'(ivl)) begin
            last = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] next_pwm_level(input logic [2:0] mode, input logic [31:0] now);
        logic [7:0] lvl;
        lvl = LEVEL_MIN;
        case (mode)
            MODE_ON: lvl = LEVEL_MAX;
            MODE_BLINK: begin
                if (step_due(blink_t, now, blink_ms))
                    blink_lvl = (blink_lvl == LEVEL_MIN) ? LEVEL_MAX : LEVEL_MIN;
                lvl = blink_lvl;
            end
            MODE_GLOW: begin
                if (step_due(glow_t, now, glow_ms)) begin
                    if (glow_up) begin
                        glow_lvl = add_sat(glow_lvl, glow_sz);
                        if (glow_lvl == LEVEL_MAX) glow_up = 1'b0;
                    end else begin
                        glow_lvl = sub_sat(glow_lvl, glow_sz);
                        if (glow_lvl == LEVEL_MIN) glow_up = 1'b1;
                    end
                end
                lvl = glow_lvl;
            end
            MODE_FADE_ON: begin
                if (step_due(up_t, now, fade_ms)) up_lvl = add_sat(up_lvl, fade_sz);
                lvl = up_lvl;
            end
            MODE_FADE_OFF: begin
                if (step_due(down_t, now, fade_ms)) down_lvl = sub_sat(down_lvl, fade_sz);
                lvl = down_lvl;
            end
            default: lvl = LEVEL_MIN;
        endcase
        return lvl;
    endfunction

    function automatic void apply_setting(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            REG_BLINK_PERIOD_MS: blink_ms = data;
            REG_GLOW_STEP_MS:    glow_ms  = data;
            REG_GLOW_STEP_SIZE:  glow_sz  = data[7:0];
            REG_FADE_STEP_MS:    fade_ms  = data;
            REG_FADE_STEP_SIZE:  fade_sz  = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue_word(input logic [2:0] mode, input logic [31:0] now,
                              input logic typed, input logic [7:0] typed_level);
        int gap;
        logic [7:0] lvl;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_now_ms <= now;
        do @(posedge aclk); while (!s_ready);
        lvl = next_pwm_level(mode, now);
        level_q.push_back(typed ? typed_level : lvl);
        words_sent++;
        @(negedge aclk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_setting(idx, data);
        regs_written++;
        @(negedge aclk);
    endtask

    task automatic drain_block();
        s_valid <= 1'b0;
        while (level_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_setting(input int p, input bit is_size);
        int r;
        if (p == 0) return 16'd1;
        if (p == 1) return 16'hFFFF;
        if (p == 2) return 16'd0;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 20) return is_size ? 16'h00FF : 16'd1;
        // sizes take full-width data; only the low byte lands
        if (is_size || r >= 80) return 16'($urandom_range(0, 16'hFFFF));
        return 16'($urandom_range(2, 400));
    endfunction

    function automatic logic [2:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return MODE_BLINK;
        if (r < 45) return MODE_GLOW;
        if (r < 60) return MODE_FADE_ON;
        if (r < 72) return MODE_FADE_OFF;
        if (r < 82) return MODE_ON;
        if (r < 90) return MODE_OFF;
        return 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    endfunction

    function automatic logic [31:0] interval_of(input logic [2:0] mode);
        case (mode)
            MODE_BLINK:                return 32'(blink_ms);
            MODE_GLOW:                 return 32'(glow_ms);
            MODE_FADE_ON, MODE_FADE_OFF: return 32'(fade_ms);
            default:                   return 32'd100;
        endcase
    endfunction

    // receiver: random stalls, plus one long hold on request
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (no_idle || $urandom_range(0, 99) < 80) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 3);
                repeat (stall) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_levels
        logic [7:0] want;
        if (aresetn && m_valid && m_ready) begin
            levels_seen++;
            if (level_q.size() == 0) begin
                report_mismatch($sformatf("level %0d with no word pending", m_pwm_level));
            end else begin
                want = level_q.pop_front();
                if (m_pwm_level !== want)
                    report_mismatch($sformatf("pwm_level got %0d want %0d", m_pwm_level, want));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d levels pending",
                     idle_cycles, level_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] clock_ms;
        logic [31:0] ivl;
        logic [2:0]  mode;
        int          run_left;
        int          r;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_mode       = MODE_OFF;
        s_now_ms     = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_BLINK_PERIOD_MS;
        cfg_data     = '0;
        no_idle      = 1'b0;
        hold_pending = 1'b0;
        err_count    = 0;
        words_sent   = 0;
        regs_written = 0;
        levels_seen  = 0;

        blink_ms = RST_BLINK_PERIOD_MS;
        glow_ms  = RST_GLOW_STEP_MS;
        glow_sz  = RST_GLOW_STEP_SIZE;
        fade_ms  = RST_FADE_STEP_MS;
        fade_sz  = RST_FADE_STEP_SIZE;
        blink_t  = '0;  blink_lvl = LEVEL_MIN;
        glow_t   = '0;  glow_lvl  = LEVEL_MIN;  glow_up = 1'b1;
        up_t     = '0;  up_lvl    = LEVEL_MIN;
        down_t   = '0;  down_lvl  = LEVEL_MIN;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NROWS; i++) begin
            if (SCRIPT[i].kind == ROW_REG) begin
                if (i == 0 || SCRIPT[i-1].kind != ROW_REG) drain_block();
                write_reg(SCRIPT[i].code, SCRIPT[i].val[15:0]);
                if (i == NROWS - 1 || SCRIPT[i+1].kind != ROW_REG) cfg_valid <= 1'b0;
            end else begin
                issue_word(SCRIPT[i].code, SCRIPT[i].val, SCRIPT[i].typed,
                           SCRIPT[i].want_level);
            end
        end

        clock_ms = 32'd70000;
        run_left = 0;
        mode     = MODE_OFF;
        for (int p = 0; p < PHASES; p++) begin
            // settings change only with the unit empty
            drain_block();
            write_reg(REG_BLINK_PERIOD_MS, pick_setting(p, 1'b0));
            write_reg(REG_GLOW_STEP_MS,    pick_setting(p, 1'b0));
            write_reg(REG_GLOW_STEP_SIZE,  pick_setting(p, 1'b1));
            write_reg(REG_FADE_STEP_MS,    pick_setting(p, 1'b0));
            write_reg(REG_FADE_STEP_SIZE,  pick_setting(p, 1'b1));
            if (p >= 3 && $urandom_range(0, 2) == 0)
                write_reg(3'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                          16'($urandom_range(0, 16'hFFFF)));
            cfg_valid <= 1'b0;

            no_idle = (p % 4 == 3) || (p == 5);
            if (p == 5) hold_pending = 1'b1;
            if (p == 4) clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 5000));

            for (int w = 0; w < PHASE_WORDS; w++) begin
                if (run_left == 0) begin
                    mode     = pick_mode();
                    run_left = $urandom_range(1, 12);
                end
                run_left--;
                ivl = interval_of(mode);
                r = $urandom_range(0, 99);
                if (r < 15)
                    ;
                else if (r < 85)
                    clock_ms += $urandom_range(ivl / 2, ivl + ivl / 4 + 1);
                else if (r < 95)
                    clock_ms += $urandom_range(0, 300);
                else
                    clock_ms = $urandom();
                issue_word(mode, clock_ms, 1'b0, LEVEL_MIN);
            end
        end

        s_valid <= 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES * 2) @(posedge aclk);

        $display("covered %0d words over %0d setting phases and %0d register writes",
                 words_sent, PHASES, regs_written);
        $display("checked %0d levels, %0d mismatches", levels_seen, err_count);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
